[sv/ray_axis_rect_intersect_top_macros.svh]
// Assertion macros shared by the ray/rectangle pipeline
`ifndef RAY_AXIS_RECT_INTERSECT_TOP_MACROS_SVH
`define RAY_AXIS_RECT_INTERSECT_TOP_MACROS_SVH
// property that must hold on every edge outside reset
`define RARI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define RARI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/rari_pkg.sv]
`timescale 1ns / 1ps
package rari_pkg;
    localparam int FRAC_BITS = 16;
    localparam int UV_BITS   = 16;
    localparam int CW        = 32;
    // numerator width: 33-bit magnitude shifted by FRAC_BITS
    localparam int NW        = 33 + FRAC_BITS;
    localparam int DW        = 32;
    // u/v divider: 33-bit offset shifted by UV_BITS
    localparam int UNW       = 33 + UV_BITS;
    localparam int UDW       = 33;
    // one divider shape serves t, u and v
    localparam int DIV_NW    = (NW > UNW) ? NW : UNW;
    localparam int DIV_DW    = UDW;

    typedef enum logic [2:0] {
        REG_PLANE_AXIS  = 3'd0,
        REG_PLANE_OFS   = 3'd1,
        REG_FIRST_LOW   = 3'd2,
        REG_FIRST_HIGH  = 3'd3,
        REG_SECOND_LOW  = 3'd4,
        REG_SECOND_HIGH = 3'd5,
        REG_MATERIAL    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        AXIS_XY   = 2'd0,
        AXIS_YZ   = 2'd1,
        AXIS_XZ   = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef struct packed {
        logic [1:0]        plane_axis;
        logic signed [31:0] plane_offset;
        logic signed [31:0] first_low;
        logic signed [31:0] first_high;
        logic signed [31:0] second_low;
        logic signed [31:0] second_high;
        logic [7:0]        material_id;
    } cfg_t;

    typedef struct packed {
        logic              is_hit;
        logic signed [31:0] hit_t;
        logic [16:0]       coord_u;
        logic [16:0]       coord_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]        hit_material;
        logic [1:0]        normal_axis;
    } result_t;

    // ray request as it travels beside the t divider
    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi;
        logic               neg;
        logic               bad;
    } ray_req_t;

    // hit data as it travels beside the u/v dividers
    typedef struct packed {
        logic               hit;
        logic signed [31:0] t;
        logic signed [31:0] px, py, pz;
        logic               zu, zv;
    } hit_info_t;

    localparam int DIV_TW = ($bits(ray_req_t) > $bits(hit_info_t)) ?
                            $bits(ray_req_t) : $bits(hit_info_t);
endpackage

[sv/rari_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per stage, fully pipelined.
// Carries a sideband tag alongside each request.
module rari_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [rari_pkg::DIV_NW-1:0] num,
    input  logic [rari_pkg::DIV_DW-1:0] den,
    input  logic [rari_pkg::DIV_TW-1:0] in_tag,
    output logic                        out_valid,
    output logic [rari_pkg::DIV_NW-1:0] quot,
    output logic [rari_pkg::DIV_TW-1:0] out_tag
);
    import rari_pkg::*;

    localparam int RW = DIV_DW + 1;

    logic              v_reg   [1:DIV_NW];
    logic [DIV_NW-1:0] q_reg   [1:DIV_NW];
    logic [DIV_DW-1:0] r_reg   [1:DIV_NW];
    logic [DIV_DW-1:0] d_reg   [1:DIV_NW];
    logic [DIV_TW-1:0] tag_reg [1:DIV_NW];

    for (genvar s = 0; s < DIV_NW; s++)
    begin : g_st
        logic              v_in;
        logic [DIV_NW-1:0] q_in;
        logic [DIV_DW-1:0] r_in;
        logic [DIV_DW-1:0] d_in;
        logic [DIV_TW-1:0] tag_in;
        logic [RW-1:0]     trial;
        logic [RW:0]       diff;
        logic              ok;
        if (s == 0)
        begin : g_head
            assign v_in   = in_valid;
            assign q_in   = num;
            assign r_in   = '0;
            assign d_in   = den;
            assign tag_in = in_tag;
        end
        else
        begin : g_body
            assign v_in   = v_reg[s];
            assign q_in   = q_reg[s];
            assign r_in   = r_reg[s];
            assign d_in   = d_reg[s];
            assign tag_in = tag_reg[s];
        end
        assign trial = {r_in, q_in[DIV_NW-1]};
        assign diff  = {1'b0, trial} - {2'b00, d_in};
        assign ok    = !diff[RW];
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (advance)
                v_reg[s+1] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                r_reg[s+1]   <= ok ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                q_reg[s+1]   <= {q_in[DIV_NW-2:0], ok};
                d_reg[s+1]   <= d_in;
                tag_reg[s+1] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_NW];
    assign quot      = q_reg[DIV_NW];
    assign out_tag   = tag_reg[DIV_NW];
endmodule

[sv/ray_axis_rect_intersect_top.sv]
`timescale 1ns / 1ps
// Ray versus axis-aligned rectangle test. Unless stalled, one ray request enters per
// cycle and one result leaves per cycle; the pipe holds 2*D+6 register stages, where
// D is the divider depth of 33 plus the larger of FRAC_BITS and 16 (49 at 16 fraction
// bits), set by two bit-per-stage pipelined dividers: one for the plane crossing t
// and one for the texture coordinates. A single global stall freezes every stage; the
// output register frees as soon as out_stall drops. Configuration is sampled along
// the pipe and must only be written while no ray is in flight.
// Misses (zero direction, t overflow, outside t range or bounds, plane axis 3)
// return is_hit 0 with every other field 0.
module ray_axis_rect_intersect_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] t_lower,
    input  logic signed [31:0] t_upper,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_hit,
    output logic signed [31:0] hit_t,
    output logic [16:0] coord_u,
    output logic [16:0] coord_v,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [7:0]  hit_material,
    output logic [1:0]  normal_axis
);
    import rari_pkg::*;
    `include "ray_axis_rect_intersect_top_macros.svh"

    cfg_t cfg_reg;
    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane_axis   <= AXIS_XY;
            cfg_reg.plane_offset <= '0;
            cfg_reg.first_low    <= '0;
            cfg_reg.first_high   <= 32'sd65536;
            cfg_reg.second_low   <= '0;
            cfg_reg.second_high  <= 32'sd65536;
            cfg_reg.material_id  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLANE_AXIS:  cfg_reg.plane_axis   <= cfg_data[1:0];
                REG_PLANE_OFS:   cfg_reg.plane_offset <= cfg_data;
                REG_FIRST_LOW:   cfg_reg.first_low    <= cfg_data;
                REG_FIRST_HIGH:  cfg_reg.first_high   <= cfg_data;
                REG_SECOND_LOW:  cfg_reg.second_low   <= cfg_data;
                REG_SECOND_HIGH: cfg_reg.second_high  <= cfg_data;
                REG_MATERIAL:    cfg_reg.material_id  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---- stage A: select axes, form numerator magnitude, sign
    logic              a_v_reg;
    ray_req_t          a_reg;
    logic [NW-1:0]     a_num_reg;
    logic [DW-1:0]     a_den_reg;

    logic signed [31:0] on, dn;
    logic signed [32:0] numv;
    logic [32:0]        nmag, dmag;
    always_comb
    begin
        case (cfg_reg.plane_axis)
            AXIS_XY: begin on = origin_z; dn = dir_z; end
            AXIS_YZ: begin on = origin_x; dn = dir_x; end
            default: begin on = origin_y; dn = dir_y; end
        endcase
        numv = 33'(cfg_reg.plane_offset) - 33'(on);
        nmag = numv[32] ? 33'(-numv) : numv;
        dmag = dn[31] ? 33'(-34'(dn)) : {1'b0, dn};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (advance)
            a_v_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                       t_lower, t_upper, numv[32] ^ dn[31],
                       (dn == 0) || (cfg_reg.plane_axis == AXIS_NONE)};
            a_num_reg <= {nmag, {FRAC_BITS{1'b0}}};
            // magnitude 2^31 fits in 32 bits unsigned
            a_den_reg <= dmag[31:0];
        end
    end

    // ---- t divider
    logic              d1_v;
    logic [DIV_NW-1:0] d1_q;
    logic [DIV_TW-1:0] d1_tag;
    rari_div u_tdiv (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(a_v_reg), .num(DIV_NW'(a_num_reg)),
        .den(DIV_DW'(a_den_reg == 0 ? DW'(1) : a_den_reg)), .in_tag(DIV_TW'(a_reg)),
        .out_valid(d1_v), .quot(d1_q), .out_tag(d1_tag));

    // ---- stage B: sign t, range check
    ray_req_t           d1_ray;
    logic               b_v_reg;
    ray_req_t           b_reg;
    logic signed [31:0] b_t_reg;
    logic               b_ok_reg;
    logic signed [31:0] tval;
    logic               tovf;
    assign d1_ray = ray_req_t'(d1_tag[$bits(ray_req_t)-1:0]);
    always_comb
    begin
        tovf = d1_ray.neg ? (d1_q > DIV_NW'(64'h8000_0000))
                          : (d1_q > DIV_NW'(64'h7FFF_FFFF));
        tval = d1_ray.neg ? 32'(-d1_q) : d1_q[31:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (advance)
            b_v_reg <= d1_v;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_reg    <= d1_ray;
            b_t_reg  <= tval;
            b_ok_reg <= !d1_ray.bad && !tovf && tval >= d1_ray.tlo && tval <= d1_ray.thi;
        end
    end

    // ---- stage C: products t*dir (exact 64-bit)
    logic               c_v_reg, c_ok_reg;
    ray_req_t           c_reg;
    logic signed [31:0] c_t_reg;
    logic signed [63:0] c_px_reg, c_py_reg, c_pz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (advance)
            c_v_reg <= b_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg    <= b_reg;
            c_t_reg  <= b_t_reg;
            c_ok_reg <= b_ok_reg;
            c_px_reg <= b_t_reg * b_reg.dx;
            c_py_reg <= b_t_reg * b_reg.dy;
            c_pz_reg <= b_t_reg * b_reg.dz;
        end
    end

    // ---- stage D: points at full precision (arithmetic shift = floor)
    logic               d_v_reg, d_ok_reg;
    logic signed [31:0] d_t_reg;
    logic signed [48:0] d_x_reg, d_y_reg, d_z_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (advance)
            d_v_reg <= c_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_ok_reg <= c_ok_reg;
            d_t_reg  <= c_t_reg;
            d_x_reg  <= 49'(c_reg.ox) + 49'(c_px_reg >>> FRAC_BITS);
            d_y_reg  <= 49'(c_reg.oy) + 49'(c_py_reg >>> FRAC_BITS);
            d_z_reg  <= 49'(c_reg.oz) + 49'(c_pz_reg >>> FRAC_BITS);
        end
    end

    // ---- stage E: bounds check, u/v numerators
    logic signed [48:0] pa, pb;
    always_comb
    begin
        case (cfg_reg.plane_axis)
            AXIS_XY: begin pa = d_x_reg; pb = d_y_reg; end
            AXIS_YZ: begin pa = d_y_reg; pb = d_z_reg; end
            default: begin pa = d_x_reg; pb = d_z_reg; end
        endcase
    end

    logic               e_v_reg;
    hit_info_t          e_reg;
    logic [UNW-1:0]     e_un_reg, e_vn_reg;
    logic [UDW-1:0]     e_ud_reg, e_vd_reg;
    logic               inb;
    logic [32:0]        spa, spb;
    logic [48:0]        ofa, ofb;
    always_comb
    begin
        inb = pa >= 49'(cfg_reg.first_low) && pa <= 49'(cfg_reg.first_high)
           && pb >= 49'(cfg_reg.second_low) && pb <= 49'(cfg_reg.second_high);
        spa = 33'(cfg_reg.first_high) - 33'(cfg_reg.first_low);
        spb = 33'(cfg_reg.second_high) - 33'(cfg_reg.second_low);
        ofa = pa - 49'(cfg_reg.first_low);
        ofb = pb - 49'(cfg_reg.second_low);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (advance)
            e_v_reg <= d_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_reg <= '{d_ok_reg && inb, d_t_reg, d_x_reg[31:0], d_y_reg[31:0],
                       d_z_reg[31:0], spa == 0, spb == 0};
            e_un_reg <= {ofa[32:0], {UV_BITS{1'b0}}};
            e_vn_reg <= {ofb[32:0], {UV_BITS{1'b0}}};
            e_ud_reg <= spa == 0 ? UDW'(1) : spa;
            e_vd_reg <= spb == 0 ? UDW'(1) : spb;
        end
    end

    // ---- u and v dividers
    logic                u_v, v_v;
    logic [DIV_NW-1:0]   u_q, v_q;
    logic [DIV_TW-1:0]   u_tag;
    logic [DIV_TW-1:0]   v_tag;
    rari_div u_udiv (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(e_v_reg), .num(DIV_NW'(e_un_reg)), .den(e_ud_reg),
        .in_tag(DIV_TW'(e_reg)),
        .out_valid(u_v), .quot(u_q), .out_tag(u_tag));
    rari_div u_vdiv (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(e_v_reg), .num(DIV_NW'(e_vn_reg)), .den(e_vd_reg),
        .in_tag(DIV_TW'(e_v_reg)),
        .out_valid(v_v), .quot(v_q), .out_tag(v_tag));

    // ---- output register
    hit_info_t h;
    result_t res_reg, res_next;
    logic    out_v_reg;
    assign h = hit_info_t'(u_tag[$bits(hit_info_t)-1:0]);
    always_comb
    begin
        res_next = '0;
        if (h.hit)
        begin
            res_next.is_hit       = 1'b1;
            res_next.hit_t        = h.t;
            res_next.coord_u      = h.zu ? 17'd0 : u_q[16:0];
            res_next.coord_v      = h.zv ? 17'd0 : v_q[16:0];
            res_next.point_x      = h.px;
            res_next.point_y      = h.py;
            res_next.point_z      = h.pz;
            res_next.hit_material = cfg_reg.material_id;
            res_next.normal_axis  = cfg_reg.plane_axis;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= u_v;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_v_reg;
    assign is_hit       = res_reg.is_hit;
    assign hit_t        = res_reg.hit_t;
    assign coord_u      = res_reg.coord_u;
    assign coord_v      = res_reg.coord_v;
    assign point_x      = res_reg.point_x;
    assign point_y      = res_reg.point_y;
    assign point_z      = res_reg.point_z;
    assign hit_material = res_reg.hit_material;
    assign normal_axis  = res_reg.normal_axis;

    `RARI_ASSERT(a_uv_lockstep, u_v == v_v && (!v_v || v_tag[0]), "u/v dividers out of step")
    `RARI_ASSERT(a_miss_zero, !(out_valid && !is_hit) || (hit_t == 0 && coord_u == 0
        && coord_v == 0 && hit_material == 0), "miss result not cleared")
    `RARI_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(res_reg),
        "stalled result changed")
    `RARI_ASSERT(a_uv_range, !out_valid || (coord_u <= 17'd65536 && coord_v <= 17'd65536),
        "texture coordinate above one")
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import rari_pkg::*;

    // Pipeline depth in register stages.
    localparam int PIPE_DEPTH = 2 * DIV_NW + 6;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi;
    } ray_t;

    typedef struct {
        logic [1:0]  axis;
        logic signed [31:0] ofs, alo, ahi, blo, bhi;
        logic [7:0]  mat;
    } rect_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic signed [31:0] t_lower, t_upper;
    logic        out_valid;
    logic        out_stall;
    logic        is_hit;
    logic signed [31:0] hit_t, point_x, point_y, point_z;
    logic [16:0] coord_u, coord_v;
    logic [7:0]  hit_material;
    logic [1:0]  normal_axis;

    ray_axis_rect_intersect_top u_top (.*);

    // Pending ray requests, and the results expected for the rays already sent.
    ray_t    ray_queue[$];
    result_t expected_hits[$];
    rect_t   rect;
    int      mismatches;
    int      hit_count;
    bit      driver_hold;     // pause the sender
    bit      hold_req;        // ask the receiver for one long hold
    bit      hold_taken;
    int      receiver_hold;   // cycles the receiver stays stalled on purpose

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Floor division by 2^FRAC_BITS of an exact product.
    function automatic longint floor_frac(longint x);
        if (x >= 0)
            return x >>> FRAC_BITS;
        return -((-x + (64'sd1 << FRAC_BITS) - 1) >>> FRAC_BITS);
    endfunction

    function automatic logic [16:0] texcoord(longint c, longint lo, longint hi);
        longint span;
        span = hi - lo;
        if (span == 0)
            return 17'd0;
        return 17'((longint'(c - lo) << UV_BITS) / span);
    endfunction

    // Compute the result of one ray against the current rectangle.
    function automatic result_t intersect_ray(ray_t r);
        result_t res;
        longint org[3], dir[3], pt[3];
        longint num, den, nmag, dmag, q, t;
        int n, a, b;
        res = '0;
        case (rect.axis)
            AXIS_XY: begin n = 2; a = 0; b = 1; end
            AXIS_YZ: begin n = 0; a = 1; b = 2; end
            AXIS_XZ: begin n = 1; a = 0; b = 2; end
            default: return res;
        endcase
        org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
        dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
        den = dir[n];
        if (den == 0)
            return res;
        num = longint'(rect.ofs) - org[n];
        nmag = num < 0 ? -num : num;
        dmag = den < 0 ? -den : den;
        q = (nmag << FRAC_BITS) / dmag;
        if ((num < 0) != (den < 0))
        begin
            if (q > 64'sd2147483648)
                return res;
            t = -q;
        end
        else
        begin
            if (q > 64'sd2147483647)
                return res;
            t = q;
        end
        if (t < r.tlo || t > r.thi)
            return res;
        for (int i = 0; i < 3; i++)
            pt[i] = org[i] + floor_frac(t * dir[i]);
        if (pt[a] < rect.alo || pt[a] > rect.ahi || pt[b] < rect.blo || pt[b] > rect.bhi)
            return res;
        res.is_hit       = 1'b1;
        res.hit_t        = 32'(t);
        res.coord_u      = texcoord(pt[a], rect.alo, rect.ahi);
        res.coord_v      = texcoord(pt[b], rect.blo, rect.bhi);
        res.point_x      = 32'(pt[0]);
        res.point_y      = 32'(pt[1]);
        res.point_z      = 32'(pt[2]);
        res.hit_material = rect.mat;
        res.normal_axis  = rect.axis;
        return res;
    endfunction

    // Record at the rising edge whether the offered ray was taken.
    bit in_taken;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && !in_stall;
    end

    // Driver: advance to the next ray once the current one is accepted.
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_valid)
                send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (send_gap > 0 && !(in_valid && ray_queue.size() > 0 && send_gap == 0))
            begin
                in_valid <= 1'b0;
                if (!in_valid)
                    send_gap <= send_gap - 1;
            end
            else if (ray_queue.size() > 0 && !driver_hold)
            begin
                ray_t r;
                r = ray_queue.pop_front();
                expected_hits.push_back(intersect_ray(r));
                in_valid <= 1'b1;
                origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
                dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
                t_lower <= r.tlo; t_upper <= r.thi;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall: random gaps, plus a long hold when requested.
    int recv_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            receiver_hold <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            out_stall <= 1'b1;
            receiver_hold <= 300;
            hold_taken <= 1'b1;
        end
        else if (receiver_hold > 0)
        begin
            out_stall <= 1'b1;
            receiver_hold <= receiver_hold - 1;
        end
        else if (recv_gap > 0)
        begin
            out_stall <= 1'b1;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && $urandom_range(0, 4) == 0)
                recv_gap <= $urandom_range(0, 18);
        end
    end

    // Monitor: compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_t got, want;
            got = '{is_hit, hit_t, coord_u, coord_v, point_x, point_y, point_z,
                    hit_material, normal_axis};
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (got.is_hit)
                    hit_count++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PLANE_AXIS:  rect.axis = value[1:0];
            REG_PLANE_OFS:   rect.ofs  = value;
            REG_FIRST_LOW:   rect.alo  = value;
            REG_FIRST_HIGH:  rect.ahi  = value;
            REG_SECOND_LOW:  rect.blo  = value;
            REG_SECOND_HIGH: rect.bhi  = value;
            default:         rect.mat  = value[7:0];
        endcase
    endtask

    task automatic set_rect(logic [1:0] axis, int ofs, int alo, int ahi, int blo, int bhi,
                            logic [7:0] mat);
        write_reg(REG_PLANE_AXIS, axis);
        write_reg(REG_PLANE_OFS, ofs);
        write_reg(REG_FIRST_LOW, alo);
        write_reg(REG_FIRST_HIGH, ahi);
        write_reg(REG_SECOND_LOW, blo);
        write_reg(REG_SECOND_HIGH, bhi);
        write_reg(REG_MATERIAL, mat);
    endtask

    // Wait until every ray in flight has come back, then let the pipe drain.
    task automatic drain;
        while (ray_queue.size() > 0 || expected_hits.size() > 0 || in_valid)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_small();
        return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    // Mostly small random rays near the origin, some raw noise.
    function automatic ray_t random_ray();
        ray_t r;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom};
            return r;
        end
        r.ox = rand_small(); r.oy = rand_small(); r.oz = rand_small();
        r.dx = rand_small(); r.dy = rand_small(); r.dz = rand_small();
        if (mode == 1)
        begin
            r.dx = 0; r.dy = 0; r.dz = 0;
        end
        r.tlo = mode == 2 ? $urandom : -(32'sd1 <<< 30);
        r.thi = mode == 3 ? $urandom : 32'sh7fffffff;
        return r;
    endfunction

    // Build a ray that reaches a point near the rect on the plane at t of one unit.
    function automatic ray_t aimed_ray();
        ray_t r;
        longint tgt[3];
        int n;
        n = rect.axis == AXIS_XY ? 2 : rect.axis == AXIS_YZ ? 0 : 1;
        tgt[0] = rect.alo + ($urandom % 2 ? 0 : $urandom_range(0, 1 << 17));
        tgt[1] = rect.axis == AXIS_XY ? rect.blo + $urandom_range(0, 1 << 17)
                                       : rect.alo + $urandom_range(0, 1 << 17);
        tgt[2] = rect.blo + $urandom_range(0, 1 << 17);
        tgt[n] = rect.ofs;
        r.dx = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        r.dy = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        r.dz = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        r.ox = 32'(tgt[0] - r.dx);
        r.oy = 32'(tgt[1] - r.dy);
        r.oz = 32'(tgt[2] - r.dz);
        r.tlo = 0;
        r.thi = 32'sh7fffffff;
        return r;
    endfunction

    function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                      int tlo, int thi);
        ray_t r;
        r = '{ox, oy, oz, dx, dy, dz, tlo, thi};
        return r;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            ray_queue.push_back($urandom_range(0, 1) ? aimed_ray() : random_ray());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_PLANE_AXIS; cfg_data = '0;
        origin_x = 0; origin_y = 0; origin_z = 0;
        dir_x = 0; dir_y = 0; dir_z = 0; t_lower = 0; t_upper = 0;
        driver_hold = 1'b0;
        hold_req = 1'b0;
        mismatches = 0;
        hit_count = 0;
        rect = '{AXIS_XY, 0, 0, 32'sd65536, 0, 32'sd65536, 8'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rays against the reset rectangle (unit square in XY at z = 0).
        ray_queue.push_back(make_ray(32768, 32768, 65536, 0, 0, -65536, 0, 32'sh7fffffff));
        ray_queue.push_back(make_ray(0, 0, 65536, 0, 0, -65536, 65536, 65536));
        ray_queue.push_back(make_ray(65536, 65536, 65536, 0, 0, -65536, 0, 65535));
        ray_queue.push_back(make_ray(0, 0, 65536, 0, 0, 0, 0, 32'sh7fffffff));
        ray_queue.push_back(make_ray(0, 0, 32'sh7fffffff, 0, 0, 1, 32'sh80000000,
                                     32'sh7fffffff));
        ray_queue.push_back(make_ray(0, 0, 32'sh80000000, 0, 0, 32'sh80000000,
                                     32'sh80000000, 32'sh7fffffff));
        ray_queue.push_back(make_ray(65537, 0, 65536, 0, 0, -65536, 0, 32'sh7fffffff));
        ray_queue.push_back(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
        ray_queue.push_back(make_ray(0, 0, -65536, 0, 0, 32'sh7fffffff,
                                     32'sh80000000, 32'sh7fffffff));
        drain();

        // Zero-width sides, inverted bounds, each axis, then the invalid axis.
        set_rect(AXIS_YZ, 65536, 0, 0, -65536, 65536, 8'hff);
        ray_queue.push_back(make_ray(0, 0, 0, 65536, 0, 0, 0, 32'sh7fffffff));
        ray_queue.push_back(make_ray(0, 0, 32768, 65536, 0, 0, 0, 32'sh7fffffff));
        drain();
        set_rect(AXIS_XZ, -65536, 65536, 0, 32'sh80000000, 32'sh7fffffff, 8'h5a);
        ray_queue.push_back(make_ray(32768, 0, 0, 0, -65536, 0, 0, 32'sh7fffffff));
        drain();
        set_rect(AXIS_NONE, 0, 0, 65536, 0, 65536, 8'h01);
        ray_queue.push_back(make_ray(32768, 32768, 65536, 0, 0, -65536, 0, 32'sh7fffffff));
        drain();

        // Random phases over several rectangles, extremes included.
        for (int p = 0; p < 8; p++)
        begin
            int lo1, lo2;
            lo1 = rand_small();
            lo2 = rand_small();
            if (p == 0)
                set_rect(AXIS_XY, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                         32'sh80000000, 32'sh7fffffff, 8'hff);
            else
                set_rect(2'($urandom_range(0, 2)), rand_small(), lo1,
                         lo1 + $urandom_range(0, 4 << 16), lo2,
                         lo2 + $urandom_range(0, 4 << 16), 8'($urandom));
            random_phase(230);
            if (p == 2)
            begin
                // Hold the receiver so the pipe fills and the input stalls.
                hold_req = 1'b1;
            end
            if (p == 4)
            begin
                // Pause the sender until all expected results are back.
                wait (ray_queue.size() < 100);
                driver_hold = 1'b1;
                while (expected_hits.size() > 0)
                    @(posedge clk);
                driver_hold = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
